@@ hw/rtl/lrc_pkg.sv @@
// Package for the logistic regression classifier.
// Holds command and register codes and fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrc_pkg;

    // cmd field codes
    localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_LOAD_MEAN   = 2'd1;
    localparam logic [1:0] CMD_LOAD_SCALE  = 2'd2;
    localparam logic [1:0] CMD_FEATURE     = 2'd3;

    // configuration register indexes
    localparam logic CFG_NORMALIZE     = 1'b0;
    localparam logic CFG_FEATURE_COUNT = 1'b1;

    // field widths
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 5;
    localparam int COUNT_W = 5;
    localparam int CONF_W  = 17;

    // sigmoid constants
    localparam logic [32:0] Q32_ONE      = 33'h1_0000_0000;
    localparam logic [19:0] ABS_LIMIT    = 20'hF_FFFF;
    localparam logic [3:0]  HORNER_TERMS = 4'd12;
    localparam logic [4:0]  FDIV_CYCLES  = 5'd17;  // 17 quotient bits, 1 per cycle
    localparam logic [1:0]  SQUARINGS    = 2'd3;   // last squaring step index

endpackage

`default_nettype wire

@@ hw/rtl/logistic_regression_classifier.sv @@
// Logistic regression inference block: parameter stores, dot product, sigmoid.
// Depends on lrc_pkg (codes, widths, constants).
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        sink       i_in_valid / o_in_ready    i_cmd, i_index, i_value
// out       source     o_out_valid / i_out_ready  o_label, o_confidence
// cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A load beat is written straight into its store. A feature beat runs a store
// read, centering and then scaling through the shared multiplier when
// normalization is on, weight multiply and accumulate. The last feature of a
// sample adds the sigmoid: 12 Horner steps (multiply, then the divide by the
// term number as a multiply by its rounded-up reciprocal, then a subtract from
// one), the squarings, and a bit-serial reciprocal divide. All multiplies use
// one shared 34x34 multiplier.
// Reset clears control state and the accumulator, turns normalization off and
// sets the feature count to one; the stores hold garbage until loaded. A
// finished result waits in the output register, and the next beat is taken
// while it waits; a second result stalls until the first is taken.

module logistic_regression_classifier #(
    parameter int MAX_FEATURES = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input beats
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [1:0]                  i_cmd,
    input  wire logic [lrc_pkg::INDEX_W-1:0] i_index,
    input  wire logic signed [lrc_pkg::VALUE_W-1:0] i_value,
    // result beats
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_label,
    output logic [lrc_pkg::CONF_W-1:0]       o_confidence,
    // configuration writes
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic                        i_cfg_index,
    input  wire logic [lrc_pkg::COUNT_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int PW = $clog2(MAX_FEATURES + 1);
    localparam logic [31:0] MAX32 = 32'(MAX_FEATURES);

    typedef enum logic [3:0] {
        S_IDLE, S_CENTER, S_SCALE, S_SAT, S_WMUL, S_ACC,
        S_SINIT, S_HMUL, S_HLOAD, S_HDIV, S_HSUB, S_SQR, S_SQW,
        S_FINIT, S_FDIV, S_OUT
    } t_state;

    // store entry: scale | mean | weight (weight of feature p is entry p)
    logic [95:0] r_store [MAX_FEATURES];
    logic [95:0] r_rd;

    t_state               r_state;
    logic                 r_normalize;
    logic [lrc_pkg::COUNT_W-1:0] r_feature_count;
    logic [PW-1:0]        r_pos;
    logic signed [31:0]   r_bias;
    logic signed [31:0]   r_val;
    logic signed [31:0]   r_x;
    logic                 r_norm;
    logic                 r_seed;
    logic                 r_last;
    logic signed [63:0]   r_acc;
    logic signed [67:0]   r_prod;
    logic [31:0]          r_u;
    logic [32:0]          r_t;
    logic [3:0]           r_n;
    logic [1:0]           r_k;
    logic [31:0]          r_dq;
    logic [34:0]          r_frem;
    logic [16:0]          r_nq;
    logic [4:0]           r_cyc;
    logic                 r_label;
    logic                 r_out_valid;
    logic                 r_out_label;
    logic [lrc_pkg::CONF_W-1:0] r_out_conf;

    logic                 w_in_acc;
    logic                 w_feat_acc;
    logic [31:0]          w_idx32;
    logic [31:0]          w_waddr32;
    logic [AW-1:0]        w_waddr;
    logic [2:0]           w_wr_lane;
    logic                 w_bias_wr;
    logic [31:0]          w_fc32;
    logic [31:0]          w_cnt32;
    logic [31:0]          w_pos32;
    logic [31:0]          w_peff32;
    logic [31:0]          w_pnext32;
    logic                 w_last;
    logic [AW-1:0]        w_raddr;
    logic signed [33:0]   w_ma;
    logic signed [33:0]   w_mb;
    logic signed [67:0]   w_prod;
    logic signed [32:0]   w_diff;
    logic signed [31:0]   w_center;
    logic [47:0]          w_sh;
    logic signed [31:0]   w_scaled;
    logic signed [63:0]   w_term;
    logic signed [63:0]   w_base;
    logic [63:0]          w_abs;
    logic [19:0]          w_a;
    logic [32:0]          w_recip;
    logic [2:0]           w_rsh;
    logic [31:0]          w_hq;
    logic [33:0]          w_den;
    logic [34:0]          w_frem;
    logic                 w_fge;
    logic [34:0]          w_frem_n;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_label      = r_out_label;
    assign o_confidence = r_out_conf;

    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_feat_acc = w_in_acc & (i_cmd == lrc_pkg::CMD_FEATURE);

    // load decode; out-of-range indexes write nothing
    assign w_idx32   = 32'(i_index);
    assign w_bias_wr = w_in_acc & (i_cmd == lrc_pkg::CMD_LOAD_WEIGHT) & (w_idx32 == 32'd0);
    assign w_wr_lane[0] = w_in_acc & (i_cmd == lrc_pkg::CMD_LOAD_WEIGHT)
                        & (w_idx32 != 32'd0) & (w_idx32 <= MAX32);
    assign w_wr_lane[1] = w_in_acc & (i_cmd == lrc_pkg::CMD_LOAD_MEAN) & (w_idx32 < MAX32);
    assign w_wr_lane[2] = w_in_acc & (i_cmd == lrc_pkg::CMD_LOAD_SCALE) & (w_idx32 < MAX32);
    assign w_waddr32 = (i_cmd == lrc_pkg::CMD_LOAD_WEIGHT) ? w_idx32 - 32'd1 : w_idx32;
    assign w_waddr   = w_waddr32[AW-1:0];

    // active count and clamped position (count lowered mid-sample ends it)
    assign w_fc32    = 32'(r_feature_count);
    assign w_cnt32   = (w_fc32 == 32'd0) ? 32'd1 : ((w_fc32 > MAX32) ? MAX32 : w_fc32);
    assign w_pos32   = 32'(r_pos);
    assign w_peff32  = (w_pos32 >= w_cnt32) ? w_cnt32 - 32'd1 : w_pos32;
    assign w_pnext32 = w_peff32 + 32'd1;
    assign w_last    = (w_pnext32 >= w_cnt32);
    assign w_raddr   = w_peff32[AW-1:0];

    // parameter store: one write lane per beat, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_lane[0]) begin
            r_store[w_waddr][31:0] <= i_value;
        end
        if (w_wr_lane[1]) begin
            r_store[w_waddr][63:32] <= i_value;
        end
        if (w_wr_lane[2]) begin
            r_store[w_waddr][95:64] <= i_value;
        end
        if (w_feat_acc) begin
            r_rd <= r_store[w_raddr];
        end
    end

    // rounded-up reciprocal of the term number and its extra shift:
    // floor(q / n) = (q * ceil(2^(32+s) / n)) >> (32+s), exact for q < 2^32
    always_comb begin
        unique case (r_n)
            4'd2: begin
                w_recip = 33'h1_0000_0000;
                w_rsh   = 3'd1;
            end
            4'd3: begin
                w_recip = 33'h1_5555_5556;
                w_rsh   = 3'd2;
            end
            4'd4: begin
                w_recip = 33'h1_0000_0000;
                w_rsh   = 3'd2;
            end
            4'd5: begin
                w_recip = 33'h1_9999_999A;
                w_rsh   = 3'd3;
            end
            4'd6: begin
                w_recip = 33'h1_5555_5556;
                w_rsh   = 3'd3;
            end
            4'd7: begin
                w_recip = 33'h1_2492_4925;
                w_rsh   = 3'd3;
            end
            4'd8: begin
                w_recip = 33'h1_0000_0000;
                w_rsh   = 3'd3;
            end
            4'd9: begin
                w_recip = 33'h1_C71C_71C8;
                w_rsh   = 3'd4;
            end
            4'd10: begin
                w_recip = 33'h1_9999_999A;
                w_rsh   = 3'd4;
            end
            4'd11: begin
                w_recip = 33'h1_745D_1746;
                w_rsh   = 3'd4;
            end
            4'd12: begin
                w_recip = 33'h1_5555_5556;
                w_rsh   = 3'd4;
            end
            default: begin
                // term one: plain pass-through
                w_recip = 33'h1_0000_0000;
                w_rsh   = 3'd0;
            end
        endcase
    end

    // shared multiplier operands
    always_comb begin
        unique case (r_state)
            S_SCALE: begin
                w_ma = {{2{r_x[31]}}, r_x};
                w_mb = {{2{r_rd[95]}}, r_rd[95:64]};
            end
            S_WMUL: begin
                w_ma = {{2{r_x[31]}}, r_x};
                w_mb = {{2{r_rd[31]}}, r_rd[31:0]};
            end
            S_HMUL: begin
                w_ma = {2'b00, r_u};
                w_mb = {1'b0, r_t};
            end
            S_HDIV: begin
                w_ma = {2'b00, r_dq};
                w_mb = {1'b0, w_recip};
            end
            S_SQR: begin
                w_ma = {1'b0, r_t};
                w_mb = {1'b0, r_t};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // centering, saturated to Q16.16
    assign w_diff   = {r_val[31], r_val} - {r_rd[63], r_rd[63:32]};
    assign w_center = (w_diff[32] != w_diff[31])
                    ? (w_diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                    : w_diff[31:0];

    // floor(c * recip / 2^16), saturated
    assign w_sh     = r_prod[63:16];
    assign w_scaled = ((&w_sh[47:31]) || !(|w_sh[47:31])) ? w_sh[31:0]
                    : (w_sh[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    // accumulate; bias seeds the first feature
    assign w_term = {{16{r_prod[63]}}, r_prod[63:16]};
    assign w_base = r_seed ? {{32{r_bias[31]}}, r_bias} : r_acc;

    // |z| clamped just below 16.0
    assign w_abs = r_acc[63] ? 64'd0 - r_acc : r_acc;
    assign w_a   = (|w_abs[63:20]) ? lrc_pkg::ABS_LIMIT : w_abs[19:0];

    // Horner quotient from the reciprocal product
    assign w_hq = 32'(r_prod[64:32] >> w_rsh);

    // final reciprocal: (2^48 + den/2) / den, one bit per cycle
    assign w_den    = {1'b0, r_t} + {1'b0, lrc_pkg::Q32_ONE};
    assign w_frem   = {r_frem[33:0], r_nq[16]};
    assign w_fge    = (w_frem >= {1'b0, w_den});
    assign w_frem_n = w_fge ? w_frem - {1'b0, w_den} : w_frem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_normalize     <= 1'b0;
            r_feature_count <= lrc_pkg::COUNT_W'(1);
            r_pos           <= '0;
            r_acc           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    lrc_pkg::CFG_NORMALIZE:     r_normalize     <= i_cfg_data[0];
                    lrc_pkg::CFG_FEATURE_COUNT: r_feature_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_bias_wr) begin
                r_bias <= i_value;
            end
            // output register: load a finished result, else drain on ready
            if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_feat_acc) begin
                        r_val   <= i_value;
                        r_norm  <= r_normalize;
                        r_seed  <= (r_pos == '0);
                        r_last  <= w_last;
                        r_pos   <= w_last ? '0 : w_pnext32[PW-1:0];
                        r_state <= S_CENTER;
                    end
                end
                S_CENTER: begin
                    if (r_norm) begin
                        r_x     <= w_center;
                        r_state <= S_SCALE;
                    end else begin
                        r_x     <= r_val;
                        r_state <= S_WMUL;
                    end
                end
                S_SCALE: begin
                    r_prod  <= w_prod;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_x     <= w_scaled;
                    r_state <= S_WMUL;
                end
                S_WMUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= w_base + w_term;
                    r_state <= r_last ? S_SINIT : S_IDLE;
                end
                S_SINIT: begin
                    r_label <= ~r_acc[63];
                    r_u     <= {w_a, 12'd0};
                    r_t     <= lrc_pkg::Q32_ONE;
                    r_n     <= lrc_pkg::HORNER_TERMS;
                    r_state <= S_HMUL;
                end
                S_HMUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_HLOAD;
                end
                S_HLOAD: begin
                    r_dq    <= r_prod[63:32];
                    r_state <= S_HDIV;
                end
                S_HDIV: begin
                    r_prod  <= w_prod;
                    r_state <= S_HSUB;
                end
                S_HSUB: begin
                    r_t <= lrc_pkg::Q32_ONE - {1'b0, w_hq};
                    if (r_n == 4'd1) begin
                        r_k     <= '0;
                        r_state <= S_SQR;
                    end else begin
                        r_n     <= r_n - 4'd1;
                        r_state <= S_HMUL;
                    end
                end
                S_SQR: begin
                    // squaring is skipped while t is exactly one
                    if (r_t[32]) begin
                        r_k <= r_k + 2'd1;
                        if (r_k == lrc_pkg::SQUARINGS) begin
                            r_state <= S_FINIT;
                        end
                    end else begin
                        r_prod  <= w_prod;
                        r_state <= S_SQW;
                    end
                end
                S_SQW: begin
                    r_t <= {1'b0, r_prod[63:32]};
                    r_k <= r_k + 2'd1;
                    r_state <= (r_k == lrc_pkg::SQUARINGS) ? S_FINIT : S_SQR;
                end
                S_FINIT: begin
                    // high part of the numerator: 2^31 + den / 2^18
                    r_frem  <= 35'h0_8000_0000 + 35'(w_den[33:18]);
                    r_nq    <= w_den[17:1];
                    r_cyc   <= '0;
                    r_state <= S_FDIV;
                end
                S_FDIV: begin
                    r_frem <= w_frem_n;
                    r_nq   <= {r_nq[15:0], w_fge};
                    r_cyc  <= r_cyc + 5'd1;
                    if (r_cyc == lrc_pkg::FDIV_CYCLES - 5'd1) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_label <= r_label;
                        r_out_conf  <= r_nq;
                        r_acc       <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
